[sv/rvn_pkg.sv]
package rvn_pkg;

   localparam int PosW = 32;
   localparam int DiffW = 33;
   localparam int MagW = 33;
   localparam int SumW = 68;
   localparam int RootW = 34;
   localparam int SepW = 31;
   localparam int SpdW = 20;
   localparam int OutSpdW = 21;
   localparam int QW = 16;
   localparam int ModeW = 2;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 31;
   localparam int QuotW = 64;
   localparam logic [QW-1:0] Q15Max = 16'sd32767;

   localparam logic [CsrIdxW-1:0] CSR_SEPARATION = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_MAX_SPEED  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_YAW_MODE   = 2'd2;

   localparam logic [ModeW-1:0] YAW_CONSTANT = 2'd0;
   localparam logic [ModeW-1:0] YAW_AWAY     = 2'd1;
   localparam logic [ModeW-1:0] YAW_TOWARD   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQUARE, ST_ROOT, ST_RPLAN, ST_QW_DIV, ST_QW_ROOT,
      ST_QZ_DIV, ST_QZ_ROOT, ST_SX_DIV, ST_SY_DIV, ST_DONE
   } state_type;

   // Operand selection for the shared root and divide units.
   typedef enum logic [2:0] {
      OP_LEN, OP_RPLAN, OP_QW, OP_QZ, OP_SX, OP_SY
   } op_type;

   typedef struct packed {
      logic   load;
      logic   start;
      op_type op;
      logic   use_div;
      logic   finish;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic facing;
      logic away;
   } stat_type;

endpackage

[sv/repulsion_velocity_from_neighbor_core.sv]
// Repulsion velocity core.
// The request channel (req_valid / req_stall) carries the own and neighbor
// positions in signed Q16.16. One request yields exactly one response on the
// rsp_ channel: planar escape speed, altitude reference, yaw quaternion and
// the moving_away and coincident flags.
// A request is taken only while the core is idle, and req_stall is high
// otherwise. After the request is taken, the offsets are squared and summed
// one axis at a time, a 34 step square root gives the length, in facing modes
// a planar root and two 64 step divisions each followed by a 34 step root give
// the quaternion, and, when moving away, two 64 step divisions give the speeds;
// then the response becomes valid. One bit-serial divider and one digit-serial
// root unit are shared.
// The response stays on the rsp_ ports while rsp_stall is high; the next
// request is taken once it has gone.
// Reset returns the registers to 3.0 m, 0.3 m/s, constant heading, and
// clears the altitude reference and the held quaternion.
// Configuration writes through csr_ should happen only while idle.
module repulsion_velocity_from_neighbor_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [31:0] req_own_x, req_own_y, req_own_z,
   input  logic [31:0] req_other_x, req_other_y, req_other_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [20:0] rsp_speed_x, rsp_speed_y,
   output logic [31:0] rsp_altitude_ref,
   output logic [15:0] rsp_quat_w, rsp_quat_z,
   output logic rsp_moving_away, rsp_coincident,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [30:0] csr_data
);
   import rvn_pkg::*;

   logic [SepW-1:0] sep_ff;
   logic [SpdW-1:0] spd_ff;
   logic [ModeW-1:0] mode_ff;
   logic req_ready, req_fire, rsp_fire;
   cmd_type cmd;
   stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= 31'd196608; spd_ff <= 20'd19661; mode_ff <= YAW_CONSTANT;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SEPARATION: sep_ff <= csr_data;
            CSR_MAX_SPEED: spd_ff <= csr_data[SpdW-1:0];
            CSR_YAW_MODE: mode_ff <= csr_data[ModeW-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = !req_ready;
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && !rsp_stall;

   rvn_control u_ctrl (
      .clock, .reset, .req_fire, .rsp_fire,
      .facing_mode(mode_ff == YAW_AWAY || mode_ff == YAW_TOWARD),
      .stat, .cmd, .req_ready, .rsp_valid
   );

   rvn_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .own_x(req_own_x), .own_y(req_own_y), .own_z(req_own_z),
      .other_x(req_other_x), .other_y(req_other_y), .other_z(req_other_z),
      .sep_dist(sep_ff), .max_speed(spd_ff), .yaw_mode(mode_ff),
      .speed_x(rsp_speed_x), .speed_y(rsp_speed_y), .altitude_ref(rsp_altitude_ref),
      .quat_w(rsp_quat_w), .quat_z(rsp_quat_z),
      .moving_away(rsp_moving_away), .coincident(rsp_coincident)
   );

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while response pending");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_moving_away && rsp_coincident)) else $error("flag conflict");
   a_zero_speed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_moving_away) |-> (rsp_speed_x == '0 && rsp_speed_y == '0))
      else $error("speed without escape");
endmodule

[sv/rvn_datapath.sv]
module rvn_datapath (
   input  logic clock,
   input  logic reset,
   input  rvn_pkg::cmd_type cmd,
   output rvn_pkg::stat_type stat,
   input  logic [31:0] own_x, own_y, own_z, other_x, other_y, other_z,
   input  logic [30:0] sep_dist,
   input  logic [19:0] max_speed,
   input  logic [1:0]  yaw_mode,
   output logic [20:0] speed_x, speed_y,
   output logic [31:0] altitude_ref,
   output logic [15:0] quat_w, quat_z,
   output logic moving_away, coincident
);
   import rvn_pkg::*;

   logic signed [DiffW-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic signed [DiffW-1:0] fa_ff, fa_in, fb_ff, fb_in;
   logic [1:0] sq_ff, sq_in;
   logic [SumW-1:0] sum_ff, sum_in, psum_ff, psum_in;
   logic [MagW-1:0] mag, adx, ady;
   logic [65:0] prod;
   logic [RootW-1:0] len_ff, len_in, rp_ff, rp_in, res_ff, res_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [SumW-1:0] rad_ff, rad_in;
   logic [RootW+1:0] srem_ff, srem_in, stry, strial;
   logic sge;
   logic [QuotW-1:0] quo_ff, quo_in, num;
   logic [RootW:0] rem_ff, rem_in, rtry;
   logic dge;
   logic [RootW-1:0] dvs_ff, dvs_in;
   logic run_ff, run_in, div_ff, div_in, sqr_ff, sqr_in;
   op_type op_ff, op_in;
   logic [15:0] qw_ff, qw_in, qz_ff, qz_in, qv;
   logic [20:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [PosW-1:0] alt_ff, alt_in;
   logic away_ff, away_in, coin_ff, coin_in, fac_ff, fac_in;
   logic signed [DiffW+1:0] rpa, rma;

   always_comb begin
      adx = dx_ff[DiffW-1] ? MagW'(-dx_ff) : MagW'(dx_ff);
      ady = dy_ff[DiffW-1] ? MagW'(-dy_ff) : MagW'(dy_ff);
      case (sq_ff)
         2'd0: mag = adx;
         2'd1: mag = ady;
         default: mag = dz_ff[DiffW-1] ? MagW'(-dz_ff) : MagW'(dz_ff);
      endcase
      prod = 66'(mag) * 66'(mag);
      // One step of the restoring divider.
      rtry = {rem_ff[RootW-1:0], quo_ff[QuotW-1]};
      dge = (rtry >= {1'b0, dvs_ff});
      // One digit of the square root: two radicand bits in, one root bit out.
      stry = {srem_ff[RootW-1:0], rad_ff[SumW-1:SumW-2]};
      strial = {res_ff, 2'b01};
      sge = (stry >= strial);
      qv = (res_ff > RootW'(Q15Max)) ? Q15Max : res_ff[15:0];
      rpa = (DiffW+2)'(signed'({1'b0, rp_ff})) + (DiffW+2)'(fa_ff);
      rma = (DiffW+2)'(signed'({1'b0, rp_ff})) - (DiffW+2)'(fa_ff);
      case (cmd.op)
         OP_QW: num = QuotW'(rpa) << 29;
         OP_QZ: num = QuotW'(rma) << 29;
         OP_SX: num = QuotW'(max_speed) * QuotW'(adx);
         default: num = QuotW'(max_speed) * QuotW'(ady);
      endcase
   end

   always_comb begin
      dx_in = dx_ff; dy_in = dy_ff; dz_in = dz_ff; fa_in = fa_ff; fb_in = fb_ff;
      sq_in = sq_ff; sum_in = sum_ff; psum_in = psum_ff; len_in = len_ff; rp_in = rp_ff;
      res_in = res_ff; cnt_in = cnt_ff; rad_in = rad_ff; srem_in = srem_ff;
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff; run_in = run_ff;
      div_in = div_ff; sqr_in = sqr_ff; op_in = op_ff; qw_in = qw_ff; qz_in = qz_ff;
      sx_in = sx_ff; sy_in = sy_ff; alt_in = alt_ff; away_in = away_ff;
      coin_in = coin_ff; fac_in = fac_ff;
      if (cmd.load) begin
         dx_in = DiffW'(signed'(other_x)) - DiffW'(signed'(own_x));
         dy_in = DiffW'(signed'(other_y)) - DiffW'(signed'(own_y));
         dz_in = DiffW'(signed'(other_z)) - DiffW'(signed'(own_z));
         if (signed'(own_z) > alt_ff) alt_in = signed'(own_z);
         sq_in = 2'd0; sum_in = '0; run_in = 1'b1;
         fac_in = (yaw_mode == YAW_AWAY) || (yaw_mode == YAW_TOWARD);
         sx_in = '0; sy_in = '0;
      end else if (run_ff) begin
         sum_in = sum_ff + SumW'(prod);
         sq_in = sq_ff + 2'd1;
         // After the y term the sum is the squared planar length.
         if (sq_ff == 2'd1) psum_in = sum_ff + SumW'(prod);
         if (sq_ff == 2'd2) begin
            run_in = 1'b0;
            if (yaw_mode == YAW_AWAY) begin fa_in = -dx_ff; fb_in = -dy_ff; end
            else begin fa_in = dx_ff; fb_in = dy_ff; end
         end
      end
      if (cmd.start) begin
         op_in = cmd.op; div_in = cmd.use_div; sqr_in = !cmd.use_div;
         cnt_in = cmd.use_div ? 6'(QuotW-1) : 6'(RootW-1);
         res_in = '0; rem_in = '0; srem_in = '0; quo_in = num;
         case (cmd.op)
            OP_LEN: rad_in = sum_ff;
            OP_RPLAN: rad_in = psum_ff;
            default: rad_in = rad_ff;
         endcase
         dvs_in = (cmd.op == OP_QW || cmd.op == OP_QZ) ? rp_ff : len_ff;
      end else if (div_ff) begin
         rem_in = dge ? rtry - {1'b0, dvs_ff} : rtry;
         quo_in = {quo_ff[QuotW-2:0], dge};
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 6'd1;
         end else begin
            div_in = 1'b0;
            // The half angle terms go on to the root of their quotient.
            if (op_ff == OP_QW || op_ff == OP_QZ) begin
               sqr_in = 1'b1; cnt_in = 6'(RootW-1); res_in = '0; srem_in = '0;
               rad_in = SumW'({quo_ff[QuotW-2:0], dge});
            end
         end
      end else if (sqr_ff) begin
         srem_in = sge ? stry - strial : stry;
         res_in = {res_ff[RootW-2:0], sge};
         rad_in = {rad_ff[SumW-3:0], 2'b00};
         if (cnt_ff != '0) cnt_in = cnt_ff - 6'd1;
         else sqr_in = 1'b0;
      end
      if (cmd.finish) begin
         case (op_ff)
            OP_LEN: begin
               len_in = res_ff;
               coin_in = (res_ff == '0);
               away_in = (res_ff != '0) && (res_ff < RootW'(sep_dist));
            end
            OP_RPLAN: begin
               rp_in = res_ff;
               if (res_ff == '0) begin qw_in = Q15Max; qz_in = '0; end
            end
            OP_QW: qw_in = qv;
            OP_QZ: qz_in = fb_ff[DiffW-1] ? -qv : qv;
            OP_SX: sx_in = dx_ff[DiffW-1] ? 21'(quo_ff) : -21'(quo_ff);
            default: sy_in = dy_ff[DiffW-1] ? 21'(quo_ff) : -21'(quo_ff);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; div_ff <= 1'b0; sqr_ff <= 1'b0; cnt_ff <= '0; alt_ff <= '0;
         qw_ff <= '0; qz_ff <= '0; op_ff <= OP_LEN;
      end else begin
         run_ff <= run_in; div_ff <= div_in; sqr_ff <= sqr_in; cnt_ff <= cnt_in;
         alt_ff <= alt_in; qw_ff <= qw_in; qz_ff <= qz_in; op_ff <= op_in;
      end
      dx_ff <= dx_in; dy_ff <= dy_in; dz_ff <= dz_in; fa_ff <= fa_in; fb_ff <= fb_in;
      sq_ff <= sq_in; sum_ff <= sum_in; psum_ff <= psum_in; len_ff <= len_in;
      rp_ff <= rp_in; res_ff <= res_in; rad_ff <= rad_in; srem_ff <= srem_in;
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in; sx_ff <= sx_in;
      sy_ff <= sy_in; away_ff <= away_in; coin_ff <= coin_in; fac_ff <= fac_in;
   end

   assign stat.busy = run_ff || div_ff || sqr_ff;
   // Read at the end of the planar root, while its result sits in res_ff.
   assign stat.facing = fac_ff && (res_ff != '0);
   assign stat.away = away_ff;
   assign speed_x = sx_ff;
   assign speed_y = sy_ff;
   assign altitude_ref = alt_ff;
   assign quat_w = qw_ff;
   assign quat_z = qz_ff;
   assign moving_away = away_ff;
   assign coincident = coin_ff;
endmodule

[sv/rvn_control.sv]
module rvn_control (
   input  logic clock,
   input  logic reset,
   input  logic req_fire,
   input  logic rsp_fire,
   input  logic facing_mode,
   input  rvn_pkg::stat_type stat,
   output rvn_pkg::cmd_type cmd,
   output logic req_ready,
   output logic rsp_valid
);
   import rvn_pkg::*;

   state_type state_ff, state_in;
   logic wait_ff, wait_in;
   logic fac_ff, fac_in;

   // wait_ff marks that the shared unit was started and has not yet ended.
   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      fac_in = fac_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) begin state_in = ST_SQUARE; fac_in = facing_mode; end
         ST_SQUARE: if (!stat.busy) begin
            state_in = fac_ff ? ST_RPLAN : ST_ROOT; wait_in = 1'b0;
         end
         ST_ROOT, ST_RPLAN, ST_QW_DIV, ST_QZ_DIV, ST_SX_DIV, ST_SY_DIV: begin
            if (!wait_ff) wait_in = 1'b1;
            else if (!stat.busy) begin
               wait_in = 1'b0;
               unique case (state_ff)
                  ST_RPLAN: state_in = ST_QW_DIV;
                  ST_QW_DIV: state_in = ST_QZ_DIV;
                  ST_QZ_DIV: state_in = ST_ROOT;
                  ST_ROOT: state_in = ST_SX_DIV;
                  ST_SX_DIV: state_in = ST_SY_DIV;
                  default: state_in = ST_DONE;
               endcase
               if (state_ff == ST_RPLAN && !stat.facing) state_in = ST_ROOT;
               if (state_ff == ST_ROOT) begin
                  state_in = ST_SX_DIV;
               end
            end
         end
         ST_DONE: if (rsp_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // Speeds are only divided out when the block moves away.
      if (state_ff == ST_SX_DIV && !wait_ff && !stat.away) state_in = ST_DONE;
   end

   always_comb begin
      cmd = '0;
      cmd.op = OP_LEN;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      cmd.load = req_fire;
      unique case (state_ff)
         ST_ROOT: cmd.op = OP_LEN;
         ST_RPLAN: cmd.op = OP_RPLAN;
         ST_QW_DIV: begin cmd.op = OP_QW; cmd.use_div = 1'b1; end
         ST_QZ_DIV: begin cmd.op = OP_QZ; cmd.use_div = 1'b1; end
         ST_SX_DIV: begin cmd.op = OP_SX; cmd.use_div = 1'b1; end
         ST_SY_DIV: begin cmd.op = OP_SY; cmd.use_div = 1'b1; end
         default: cmd.op = OP_LEN;
      endcase
      if (state_ff != ST_IDLE && state_ff != ST_SQUARE && state_ff != ST_DONE) begin
         cmd.start = !wait_ff && !(state_ff == ST_SX_DIV && !stat.away);
         cmd.finish = wait_ff && !stat.busy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; wait_ff <= 1'b0; fac_ff <= 1'b0;
      end else begin
         state_ff <= state_in; wait_ff <= wait_in; fac_ff <= fac_in;
      end
   end
endmodule
